// ===== rtl/core/prd_pkg.sv =====
// shared types and codes for the ppm stream decoder
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

  typedef enum logic [1:0] {
    KIND_SIZE   = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_NOT_RGB   = 3'd2,
    ERR_SIZE      = 3'd3,
    ERR_MAXVAL    = 3'd4,
    ERR_TRUNCATED = 3'd5,
    ERR_NUMBER    = 3'd6
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] sample_or_width;
    logic [15:0] height;
    logic        binary_format;
    err_e        error_code;
    logic        last_of_run;
  } res_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  localparam int unsigned QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== rtl/core/prd_parser.sv =====
// byte parser: header tokens, sample decode and end-of-file handling
`timescale 1ns / 1ps
`default_nettype none

module prd_parser #(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           last_byte_i,
  output prd_pkg::push_t      push_o
);
  import prd_pkg::*;

  localparam int unsigned TV_W = DIM_BITS + 1;
  localparam int unsigned T_W  = DIM_BITS + 5;
  localparam int unsigned SL_W = 2 * DIM_BITS + 2;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_SIX  = 8'h36;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXVAL = 3'd3,
    PH_RAW    = 3'd4,
    PH_ASCII  = 3'd5,
    PH_END    = 3'd6
  } phase_e;

  phase_e              ph_q, ph_d;
  logic                incom_q, incom_d;
  logic                intok_q, intok_d;
  logic [TV_W-1:0]     tv_q, tv_d;
  logic [2:0]          tl_q, tl_d;
  logic                mfo_q, mfo_d;
  logic [7:0]          msec_q, msec_d;
  logic                isb_q, isb_d;
  logic [DIM_BITS-1:0] wd_q, wd_d;
  logic [DIM_BITS-1:0] hd_q, hd_d;
  logic [SL_W-1:0]     sl_q, sl_d;
  logic [SL_W-1:0]     prod_q, prod_d;

  logic [2*DIM_BITS-1:0] wh;
  logic [T_W-1:0]        tv_ext, t_acc, t_sat;
  logic                  is_ws, is_digit, is_hash;
  logic                  fin, emit;
  logic [7:0]            emit_val;
  logic [TV_W-1:0]       v;
  logic [1:0]            cnt;
  res_t                  slot [2];

  // 3*w*h, ready in the cycle after the height is stored
  always_comb begin
    wh     = wd_q * hd_q;
    prod_d = SL_W'(wh) + (SL_W'(wh) << 1);
  end

  always_comb begin
    is_ws    = data_byte_i inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    is_digit = data_byte_i inside {[CH_ZERO:CH_NINE]};
    is_hash  = (data_byte_i == CH_HASH);
    tv_ext   = T_W'(tv_q);
    t_acc    = (tv_ext << 3) + (tv_ext << 1) + T_W'(data_byte_i - CH_ZERO);
    t_sat    = (t_acc > (T_W'(1) << DIM_BITS)) ? (T_W'(1) << DIM_BITS) : t_acc;
  end

  always_comb begin
    ph_d     = ph_q;
    incom_d  = incom_q;
    intok_d  = intok_q;
    tv_d     = tv_q;
    tl_d     = tl_q;
    mfo_d    = mfo_q;
    msec_d   = msec_q;
    isb_d    = isb_q;
    wd_d     = wd_q;
    hd_d     = hd_q;
    sl_d     = sl_q;
    cnt      = 2'd0;
    slot[0]  = '0;
    slot[1]  = '0;
    fin      = 1'b0;
    emit     = 1'b0;
    emit_val = data_byte_i;
    v        = tv_q;

    if (accept_i) begin
      // per-byte step, except the token finish and sample emission
      if (ph_q == PH_RAW) begin
        emit = 1'b1;
      end else if (ph_q != PH_END) begin
        if (incom_q) begin
          if (data_byte_i == CH_LF) begin
            incom_d = 1'b0;
          end
        end else if (is_ws || is_hash) begin
          fin = intok_q;
        end else begin
          intok_d = 1'b1;
          if (ph_q == PH_MAGIC) begin
            if (tl_q == 3'd0) begin
              mfo_d = (data_byte_i == CH_P);
            end else if (tl_q == 3'd1) begin
              msec_d = data_byte_i;
            end
            if (tl_q != 3'd7) begin
              tl_d = tl_q + 3'd1;
            end
          end else if (is_digit) begin
            if (ph_q == PH_ASCII) begin
              tv_d = TV_W'(t_acc[7:0]);
            end else begin
              tv_d = t_sat[TV_W-1:0];
            end
            if (tl_q != 3'd7) begin
              tl_d = tl_q + 3'd1;
            end
          end else begin
            slot[cnt[0]] = '{KIND_ERROR, 16'd0, 16'd0, isb_d, ERR_NUMBER, 1'b0};
            cnt     = cnt + 2'd1;
            ph_d    = PH_END;
            intok_d = 1'b0;
            incom_d = 1'b0;
          end
        end
      end

      // end of file closes an open token
      if (last_byte_i && (ph_d != PH_END) && intok_d) begin
        fin = 1'b1;
      end

      if (fin) begin
        v       = tv_d;
        intok_d = 1'b0;
        tv_d    = '0;
        case (ph_d)
          PH_MAGIC: begin
            if ((tl_d != 3'd2) || !mfo_d) begin
              slot[cnt[0]] = '{KIND_ERROR, 16'd0, 16'd0, isb_d, ERR_MAGIC, 1'b0};
              cnt     = cnt + 2'd1;
              ph_d    = PH_END;
              incom_d = 1'b0;
            end else if (msec_d == CH_SIX) begin
              isb_d = 1'b1;
              ph_d  = PH_WIDTH;
            end else if (msec_d == CH_THREE) begin
              isb_d = 1'b0;
              ph_d  = PH_WIDTH;
            end else begin
              slot[cnt[0]] = '{KIND_ERROR, 16'd0, 16'd0, isb_d, ERR_NOT_RGB, 1'b0};
              cnt     = cnt + 2'd1;
              ph_d    = PH_END;
              incom_d = 1'b0;
            end
          end
          PH_WIDTH, PH_HEIGHT: begin
            if ((v == '0) || v[DIM_BITS]) begin
              slot[cnt[0]] = '{KIND_ERROR, 16'd0, 16'd0, isb_d, ERR_SIZE, 1'b0};
              cnt     = cnt + 2'd1;
              ph_d    = PH_END;
              incom_d = 1'b0;
            end else if (ph_d == PH_WIDTH) begin
              wd_d = v[DIM_BITS-1:0];
              ph_d = PH_HEIGHT;
            end else begin
              hd_d = v[DIM_BITS-1:0];
              ph_d = PH_MAXVAL;
            end
          end
          PH_MAXVAL: begin
            if (isb_d ? (v != TV_W'(255)) : (v > TV_W'(255))) begin
              slot[cnt[0]] = '{KIND_ERROR, 16'd0, 16'd0, isb_d, ERR_MAXVAL, 1'b0};
              cnt     = cnt + 2'd1;
              ph_d    = PH_END;
              incom_d = 1'b0;
            end else begin
              sl_d = prod_q;
              slot[cnt[0]] = '{KIND_SIZE, 16'(wd_d), 16'(hd_d), isb_d, ERR_NONE, 1'b0};
              cnt  = cnt + 2'd1;
              ph_d = isb_d ? PH_RAW : PH_ASCII;
            end
          end
          PH_ASCII: begin
            emit     = 1'b1;
            emit_val = v[7:0];
          end
          default: begin
          end
        endcase
        tl_d   = 3'd0;
        mfo_d  = 1'b0;
        msec_d = 8'd0;
      end

      if (emit) begin
        slot[cnt[0]] = '{KIND_SAMPLE, 16'(emit_val), 16'd0, isb_d, ERR_NONE, 1'b0};
        cnt = cnt + 2'd1;
        if (sl_d != '0) begin
          sl_d = sl_d - SL_W'(1);
        end
        if (sl_d == '0) begin
          slot[cnt[0]] = '{KIND_DONE, 16'd0, 16'd0, isb_d, ERR_NONE, 1'b0};
          cnt  = cnt + 2'd1;
          ph_d = PH_END;
        end
      end

      // a hash outside a comment starts a comment, also one that ends a token
      if (!incom_q && is_hash && (ph_q != PH_RAW) && (ph_q != PH_END) &&
          (ph_d != PH_RAW) && (ph_d != PH_END)) begin
        incom_d = 1'b1;
      end

      if (last_byte_i) begin
        if (ph_d != PH_END) begin
          slot[cnt[0]] = '{KIND_ERROR, 16'd0, 16'd0, isb_d, ERR_TRUNCATED, 1'b0};
          cnt = cnt + 2'd1;
        end
        ph_d    = PH_MAGIC;
        incom_d = 1'b0;
        intok_d = 1'b0;
        tv_d    = '0;
        tl_d    = 3'd0;
        mfo_d   = 1'b0;
        msec_d  = 8'd0;
        isb_d   = 1'b0;
        wd_d    = '0;
        hd_d    = '0;
        sl_d    = '0;
      end

      if (cnt == 2'd1) begin
        slot[0].last_of_run = 1'b1;
      end else if (cnt == 2'd2) begin
        slot[1].last_of_run = 1'b1;
      end
    end

    push_o.cnt = cnt;
    push_o.r0  = slot[0];
    push_o.r1  = slot[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_MAGIC;
      incom_q <= 1'b0;
      intok_q <= 1'b0;
      tv_q    <= '0;
      tl_q    <= 3'd0;
      mfo_q   <= 1'b0;
      msec_q  <= 8'd0;
      isb_q   <= 1'b0;
      wd_q    <= '0;
      hd_q    <= '0;
      sl_q    <= '0;
    end else begin
      ph_q    <= ph_d;
      incom_q <= incom_d;
      intok_q <= intok_d;
      tv_q    <= tv_d;
      tl_q    <= tl_d;
      mfo_q   <= mfo_d;
      msec_q  <= msec_d;
      isb_q   <= isb_d;
      wd_q    <= wd_d;
      hd_q    <= hd_d;
      sl_q    <= sl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/prd_res_queue.sv =====
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps
`default_nettype none

module prd_res_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire prd_pkg::push_t push_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output prd_pkg::res_t       head_o
);
  import prd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  res_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  // room for two results is needed before taking a byte
  assign full_o  = (cnt_q > CW'(QUEUE_DEPTH - 2));
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q + PW'(push_i.cnt);
    rd_d  = rd_q + PW'(pop);
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + PW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ppm_rgb_stream_decoder.sv =====
// top level of the ppm (p6 / p3) byte stream decoder
//
// channel | direction | handshake               | payload
// in      | input     | in_valid_i, in_stall_o   | data_byte_i, last_byte_i
// out     | output    | out_valid_o, out_stall_i | kind_o, sample_or_width_o, height_o,
//         |           |                          | binary_format_o, error_code_o, last_of_run_o
//
// one byte is taken per cycle while in_stall_o is low; its results are written
// to a four-entry result queue at the same clock edge and reach the output behind
// earlier results. a byte yields up to two results and the output drains one a
// cycle while out_stall_i is low, so the input stalls while under two entries are free.
// reset leaves the parser waiting for a magic token with an empty queue.
`timescale 1ns / 1ps
`default_nettype none

module ppm_rgb_stream_decoder #(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [15:0]      sample_or_width_o,
  output logic [15:0]      height_o,
  output logic             binary_format_o,
  output logic [2:0]       error_code_o,
  output logic             last_of_run_o
);
  import prd_pkg::*;

  push_t push;
  res_t  head;
  logic  full;
  logic  accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  prd_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .push_o     (push)
  );

  prd_res_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .valid_o(out_valid_o),
    .pop_i  (!out_stall_i),
    .head_o (head)
  );

  assign kind_o            = head.kind;
  assign sample_or_width_o = head.sample_or_width;
  assign height_o          = head.height;
  assign binary_format_o   = head.binary_format;
  assign error_code_o      = head.error_code;
  assign last_of_run_o     = head.last_of_run;

endmodule

`default_nettype wire
